// File: sv/ea2rm_pkg.sv
// Constants, types and tables for the z-x-z Euler angle to rotation matrix pipeline.
`timescale 1ns / 1ps

package ea2rm_pkg;

   localparam int ANGLE_BITS   = 16;
   localparam int ENTRY_BITS   = 16;
   localparam int CORDIC_STEPS = 16;

   localparam int NUM_LANES = 3;
   localparam int LANE_PHI  = 0;
   localparam int LANE_TH   = 1;
   localparam int LANE_PSI  = 2;
   localparam int NUM_ENTRIES = 9;

   // angle to phase: full turn is 2^32, 2^34/pi scaled by 2^-16 after the product
   localparam int KTURN_W = 34;
   localparam logic signed [KTURN_W-1:0] TURN_K = 34'sd5468522205;
   localparam int MUL_W   = (ANGLE_BITS + KTURN_W > 48) ? ANGLE_BITS + KTURN_W : 48;
   localparam int PROD_W  = 48;
   localparam logic [PROD_W-1:0] PHASE_RND = PROD_W'(32768);
   localparam int PHASE_W = 32;
   localparam int RES_W   = 30;
   localparam int HPI_W   = 31;
   localparam logic [HPI_W-1:0] HALF_PI_Q30 = 31'd1686629713;
   localparam int RMUL_W  = RES_W + HPI_W;
   localparam int ZR_W    = RMUL_W - 30;

   localparam int XY_W = 34;
   localparam int Z_W  = 34;
   localparam int TABLE_LEN = 30;

   typedef logic signed [XY_W-1:0] xy_type;
   typedef logic signed [Z_W-1:0]  z_type;

   localparam xy_type INV_GAIN_Q30 = XY_W'(652032874);
   localparam xy_type TRIG_RND     = XY_W'(8192);
   localparam xy_type TRIG_MAX_X   = XY_W'(65536);

   localparam int TRIG_W   = 18;
   localparam int PAIR_W   = 34;
   localparam int TRIPLE_W = 50;
   localparam int SUM_W    = 51;

   typedef logic signed [TRIG_W-1:0]   trig_type;
   typedef logic signed [PAIR_W-1:0]   pair_type;
   typedef logic signed [TRIPLE_W-1:0] triple_type;
   typedef logic signed [SUM_W-1:0]    sum_type;
   typedef logic signed [ENTRY_BITS-1:0] entry_type;

   localparam int ENTRY_LIM = (ENTRY_BITS - 1 < 15) ? (1 << (ENTRY_BITS - 1)) - 1 : 16384;
   localparam sum_type   ENTRY_RND   = SUM_W'(64'd1 << 33);
   localparam sum_type   ENTRY_LIM_S = SUM_W'(ENTRY_LIM);
   localparam entry_type ENTRY_LIM_E = ENTRY_BITS'(ENTRY_LIM);

   typedef enum logic [1:0] {
      QUAD_0 = 2'd0,
      QUAD_1 = 2'd1,
      QUAD_2 = 2'd2,
      QUAD_3 = 2'd3
   } quad_type;

   // pipeline stage numbers, 1 is the stage loaded at the accepting edge
   localparam int ST_PROD  = 1;
   localparam int ST_PHASE = 2;
   localparam int ST_RES   = 3;
   localparam int ST_MAP   = CORDIC_STEPS + 4;
   localparam int ST_PAIR  = CORDIC_STEPS + 5;
   localparam int ST_TRIP  = CORDIC_STEPS + 6;
   localparam int ST_SUM   = CORDIC_STEPS + 7;
   localparam int NUM_STAGES = CORDIC_STEPS + 8;

   function automatic logic [29:0] atan_q30(input logic [4:0] idx);
      logic [29:0] v;
      case (idx)
         5'd0:  v = 30'h3243F6A8;
         5'd1:  v = 30'h1DAC6705;
         5'd2:  v = 30'h0FADBAFC;
         5'd3:  v = 30'h07F56EA6;
         5'd4:  v = 30'h03FEAB76;
         5'd5:  v = 30'h01FFD55B;
         5'd6:  v = 30'h00FFFAAA;
         5'd7:  v = 30'h007FFF55;
         5'd8:  v = 30'h003FFFEA;
         5'd9:  v = 30'h001FFFFD;
         5'd10: v = 30'h000FFFFF;
         5'd11: v = 30'h0007FFFF;
         5'd12: v = 30'h0003FFFF;
         5'd13: v = 30'h0001FFFF;
         5'd14: v = 30'h0000FFFF;
         5'd15: v = 30'h00007FFF;
         5'd16: v = 30'h00003FFF;
         5'd17: v = 30'h00001FFF;
         5'd18: v = 30'h00000FFF;
         5'd19: v = 30'h000007FF;
         5'd20: v = 30'h000003FF;
         5'd21: v = 30'h000001FF;
         5'd22: v = 30'h000000FF;
         5'd23: v = 30'h0000007F;
         5'd24: v = 30'h0000003F;
         5'd25: v = 30'h0000001F;
         5'd26: v = 30'h0000000F;
         5'd27: v = 30'h00000007;
         5'd28: v = 30'h00000003;
         5'd29: v = 30'h00000001;
         default: v = 30'h0;
      endcase
      return v;
   endfunction

endpackage

// File: sv/euler_angles_to_rotation_matrix_core.sv
// Top level: pipelined z-x-z Euler angle to 3x3 rotation matrix converter.
// Stages: product, phase, residual, one per CORDIC step, map, pair, triple, sum, output register.
// Throughput: one triplet per cycle unless full and stalled; one CORDIC step per stage sets depth.
// Each stage advances when the stage after it is empty or advancing; bubbles collapse under stall.
// Reset clears all stage valid bits; data registers are not reset.
`timescale 1ns / 1ps

module euler_angles_to_rotation_matrix_core (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  logic signed [ea2rm_pkg::ANGLE_BITS-1:0] req_angle_phi,
   input  logic signed [ea2rm_pkg::ANGLE_BITS-1:0] req_angle_theta,
   input  logic signed [ea2rm_pkg::ANGLE_BITS-1:0] req_angle_psi,
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic signed [ea2rm_pkg::ENTRY_BITS-1:0] rsp_row0_col0,
   output logic signed [ea2rm_pkg::ENTRY_BITS-1:0] rsp_row0_col1,
   output logic signed [ea2rm_pkg::ENTRY_BITS-1:0] rsp_row0_col2,
   output logic signed [ea2rm_pkg::ENTRY_BITS-1:0] rsp_row1_col0,
   output logic signed [ea2rm_pkg::ENTRY_BITS-1:0] rsp_row1_col1,
   output logic signed [ea2rm_pkg::ENTRY_BITS-1:0] rsp_row1_col2,
   output logic signed [ea2rm_pkg::ENTRY_BITS-1:0] rsp_row2_col0,
   output logic signed [ea2rm_pkg::ENTRY_BITS-1:0] rsp_row2_col1,
   output logic signed [ea2rm_pkg::ENTRY_BITS-1:0] rsp_row2_col2
);

   localparam int NS = ea2rm_pkg::NUM_STAGES;
   localparam int NL = ea2rm_pkg::NUM_LANES;
   localparam int NC = ea2rm_pkg::CORDIC_STEPS;

   // stage valid bits and advance enables
   logic [NS:1] v_ff, v_in, en, v_prev;

   for (genvar k = 1; k <= NS; k++) begin : g_en
      assign en[k] = !rsp_stall || !(&v_ff[NS:k]);
   end

   assign v_prev = {v_ff[NS-1:1], req_valid};
   assign v_in   = (en & v_prev) | (~en & v_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   assign req_stall = !en[1];
   assign rsp_valid = v_ff[NS];

   // stage 1: angle times turn constant
   logic signed [ea2rm_pkg::ANGLE_BITS-1:0] ang [NL];
   logic signed [ea2rm_pkg::MUL_W-1:0] prod_in [NL];
   logic [ea2rm_pkg::PROD_W-1:0] prod_ff [NL];

   assign ang[ea2rm_pkg::LANE_PHI] = req_angle_phi;
   assign ang[ea2rm_pkg::LANE_TH]  = req_angle_theta;
   assign ang[ea2rm_pkg::LANE_PSI] = req_angle_psi;

   always_comb begin
      for (int l = 0; l < NL; l++) begin
         prod_in[l] = ang[l] * ea2rm_pkg::TURN_K;
      end
   end

   always_ff @(posedge clock) begin
      if (en[ea2rm_pkg::ST_PROD]) begin
         for (int l = 0; l < NL; l++) begin
            prod_ff[l] <= prod_in[l][ea2rm_pkg::PROD_W-1:0];
         end
      end
   end

   // stage 2: round to 32-bit phase
   logic [ea2rm_pkg::PROD_W-1:0] phase_sum [NL];
   logic [ea2rm_pkg::PHASE_W-1:0] phase_ff [NL];

   always_comb begin
      for (int l = 0; l < NL; l++) begin
         phase_sum[l] = prod_ff[l] + ea2rm_pkg::PHASE_RND;
      end
   end

   always_ff @(posedge clock) begin
      if (en[ea2rm_pkg::ST_PHASE]) begin
         for (int l = 0; l < NL; l++) begin
            phase_ff[l] <= phase_sum[l][ea2rm_pkg::PROD_W-1:ea2rm_pkg::PROD_W-ea2rm_pkg::PHASE_W];
         end
      end
   end

   // stage 3: residual phase to Q30 radians, split off quadrant
   logic [ea2rm_pkg::RMUL_W-1:0] res_in [NL];
   logic [ea2rm_pkg::ZR_W-1:0] zr_ff [NL];
   ea2rm_pkg::quad_type quad_ff [NL];

   always_comb begin
      for (int l = 0; l < NL; l++) begin
         res_in[l] = ea2rm_pkg::RMUL_W'(phase_ff[l][ea2rm_pkg::RES_W-1:0])
                   * ea2rm_pkg::RMUL_W'(ea2rm_pkg::HALF_PI_Q30);
      end
   end

   always_ff @(posedge clock) begin
      if (en[ea2rm_pkg::ST_RES]) begin
         for (int l = 0; l < NL; l++) begin
            zr_ff[l]   <= res_in[l][ea2rm_pkg::RMUL_W-1:30];
            quad_ff[l] <= ea2rm_pkg::quad_type'(phase_ff[l][ea2rm_pkg::PHASE_W-1:ea2rm_pkg::RES_W]);
         end
      end
   end

   // CORDIC: one micro-rotation per stage
   ea2rm_pkg::xy_type cx_ff [NC][NL];
   ea2rm_pkg::xy_type cy_ff [NC][NL];
   ea2rm_pkg::z_type  cz_ff [NC][NL];
   ea2rm_pkg::quad_type cq_ff [NC][NL];

   for (genvar i = 0; i < NC; i++) begin : g_step
      localparam ea2rm_pkg::z_type ATAN_I = ea2rm_pkg::Z_W'(ea2rm_pkg::atan_q30(5'(i)));
      ea2rm_pkg::xy_type xs [NL];
      ea2rm_pkg::xy_type ys [NL];
      ea2rm_pkg::z_type  zs [NL];
      ea2rm_pkg::quad_type qs [NL];

      if (i == 0) begin : g_src_first
         always_comb begin
            for (int l = 0; l < NL; l++) begin
               xs[l] = ea2rm_pkg::INV_GAIN_Q30;
               ys[l] = '0;
               zs[l] = ea2rm_pkg::Z_W'(zr_ff[l]);
               qs[l] = quad_ff[l];
            end
         end
      end else begin : g_src_prev
         always_comb begin
            for (int l = 0; l < NL; l++) begin
               xs[l] = cx_ff[i-1][l];
               ys[l] = cy_ff[i-1][l];
               zs[l] = cz_ff[i-1][l];
               qs[l] = cq_ff[i-1][l];
            end
         end
      end

      always_ff @(posedge clock) begin
         if (en[ea2rm_pkg::ST_RES+1+i]) begin
            for (int l = 0; l < NL; l++) begin
               if (!zs[l][ea2rm_pkg::Z_W-1]) begin
                  cx_ff[i][l] <= xs[l] - (ys[l] >>> i);
                  cy_ff[i][l] <= ys[l] + (xs[l] >>> i);
                  cz_ff[i][l] <= zs[l] - ATAN_I;
               end else begin
                  cx_ff[i][l] <= xs[l] + (ys[l] >>> i);
                  cy_ff[i][l] <= ys[l] - (xs[l] >>> i);
                  cz_ff[i][l] <= zs[l] + ATAN_I;
               end
               cq_ff[i][l] <= qs[l];
            end
         end
      end
   end

   // quadrant map, round Q30 to Q16, clamp
   ea2rm_pkg::xy_type mc [NL];
   ea2rm_pkg::xy_type ms [NL];
   ea2rm_pkg::xy_type rc [NL];
   ea2rm_pkg::xy_type rs [NL];
   ea2rm_pkg::trig_type cos_in [NL];
   ea2rm_pkg::trig_type sin_in [NL];
   ea2rm_pkg::trig_type cos_ff [NL];
   ea2rm_pkg::trig_type sin_ff [NL];

   always_comb begin
      for (int l = 0; l < NL; l++) begin
         case (cq_ff[NC-1][l])
            ea2rm_pkg::QUAD_0: begin
               mc[l] = cx_ff[NC-1][l];
               ms[l] = cy_ff[NC-1][l];
            end
            ea2rm_pkg::QUAD_1: begin
               mc[l] = -cy_ff[NC-1][l];
               ms[l] = cx_ff[NC-1][l];
            end
            ea2rm_pkg::QUAD_2: begin
               mc[l] = -cx_ff[NC-1][l];
               ms[l] = -cy_ff[NC-1][l];
            end
            default: begin
               mc[l] = cy_ff[NC-1][l];
               ms[l] = -cx_ff[NC-1][l];
            end
         endcase
         rc[l] = (mc[l] + ea2rm_pkg::TRIG_RND) >>> 14;
         rs[l] = (ms[l] + ea2rm_pkg::TRIG_RND) >>> 14;
         if (rc[l] > ea2rm_pkg::TRIG_MAX_X) begin
            cos_in[l] = ea2rm_pkg::TRIG_W'(ea2rm_pkg::TRIG_MAX_X);
         end else if (rc[l] < -ea2rm_pkg::TRIG_MAX_X) begin
            cos_in[l] = ea2rm_pkg::TRIG_W'(-ea2rm_pkg::TRIG_MAX_X);
         end else begin
            cos_in[l] = ea2rm_pkg::TRIG_W'(rc[l]);
         end
         if (rs[l] > ea2rm_pkg::TRIG_MAX_X) begin
            sin_in[l] = ea2rm_pkg::TRIG_W'(ea2rm_pkg::TRIG_MAX_X);
         end else if (rs[l] < -ea2rm_pkg::TRIG_MAX_X) begin
            sin_in[l] = ea2rm_pkg::TRIG_W'(-ea2rm_pkg::TRIG_MAX_X);
         end else begin
            sin_in[l] = ea2rm_pkg::TRIG_W'(rs[l]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[ea2rm_pkg::ST_MAP]) begin
         for (int l = 0; l < NL; l++) begin
            cos_ff[l] <= cos_in[l];
            sin_ff[l] <= sin_in[l];
         end
      end
   end

   // pairwise products
   ea2rm_pkg::trig_type cphi, sphi, cth, sth, cpsi, spsi;
   assign cphi = cos_ff[ea2rm_pkg::LANE_PHI];
   assign sphi = sin_ff[ea2rm_pkg::LANE_PHI];
   assign cth  = cos_ff[ea2rm_pkg::LANE_TH];
   assign sth  = sin_ff[ea2rm_pkg::LANE_TH];
   assign cpsi = cos_ff[ea2rm_pkg::LANE_PSI];
   assign spsi = sin_ff[ea2rm_pkg::LANE_PSI];

   ea2rm_pkg::pair_type cpsi_cphi_ff, cpsi_sphi_ff, spsi_cphi_ff, spsi_sphi_ff;
   ea2rm_pkg::pair_type spsi_cth_ff, cpsi_cth_ff, spsi_sth_ff, cpsi_sth_ff;
   ea2rm_pkg::pair_type sth_sphi_ff, sth_cphi_ff;
   ea2rm_pkg::trig_type cphi_ff, sphi_ff, cth_ff;

   always_ff @(posedge clock) begin
      if (en[ea2rm_pkg::ST_PAIR]) begin
         cpsi_cphi_ff <= cpsi * cphi;
         cpsi_sphi_ff <= cpsi * sphi;
         spsi_cphi_ff <= spsi * cphi;
         spsi_sphi_ff <= spsi * sphi;
         spsi_cth_ff  <= spsi * cth;
         cpsi_cth_ff  <= cpsi * cth;
         spsi_sth_ff  <= spsi * sth;
         cpsi_sth_ff  <= cpsi * sth;
         sth_sphi_ff  <= sth * sphi;
         sth_cphi_ff  <= sth * cphi;
         cphi_ff      <= cphi;
         sphi_ff      <= sphi;
         cth_ff       <= cth;
      end
   end

   // three-factor products; carry two-factor terms along
   ea2rm_pkg::triple_type t0_ff, t1_ff, t3_ff, t4_ff;
   ea2rm_pkg::pair_type p0_ff, p1_ff, p2_ff, p3_ff, p4_ff, p5_ff, p6_ff, p7_ff;
   ea2rm_pkg::trig_type cth2_ff;

   always_ff @(posedge clock) begin
      if (en[ea2rm_pkg::ST_TRIP]) begin
         t0_ff   <= spsi_cth_ff * sphi_ff;
         t1_ff   <= spsi_cth_ff * cphi_ff;
         t3_ff   <= cpsi_cth_ff * sphi_ff;
         t4_ff   <= cpsi_cth_ff * cphi_ff;
         p0_ff   <= cpsi_cphi_ff;
         p1_ff   <= cpsi_sphi_ff;
         p2_ff   <= spsi_sth_ff;
         p3_ff   <= spsi_cphi_ff;
         p4_ff   <= spsi_sphi_ff;
         p5_ff   <= cpsi_sth_ff;
         p6_ff   <= sth_sphi_ff;
         p7_ff   <= sth_cphi_ff;
         cth2_ff <= cth_ff;
      end
   end

   // entries in Q48
   ea2rm_pkg::sum_type q_in [ea2rm_pkg::NUM_ENTRIES];
   ea2rm_pkg::sum_type q_ff [ea2rm_pkg::NUM_ENTRIES];

   always_comb begin
      q_in[0] = (ea2rm_pkg::SUM_W'(p0_ff) <<< 16) - ea2rm_pkg::SUM_W'(t0_ff);
      q_in[1] = -(ea2rm_pkg::SUM_W'(p1_ff) <<< 16) - ea2rm_pkg::SUM_W'(t1_ff);
      q_in[2] = ea2rm_pkg::SUM_W'(p2_ff) <<< 16;
      q_in[3] = (ea2rm_pkg::SUM_W'(p3_ff) <<< 16) + ea2rm_pkg::SUM_W'(t3_ff);
      q_in[4] = -(ea2rm_pkg::SUM_W'(p4_ff) <<< 16) + ea2rm_pkg::SUM_W'(t4_ff);
      q_in[5] = -(ea2rm_pkg::SUM_W'(p5_ff) <<< 16);
      q_in[6] = ea2rm_pkg::SUM_W'(p6_ff) <<< 16;
      q_in[7] = ea2rm_pkg::SUM_W'(p7_ff) <<< 16;
      q_in[8] = ea2rm_pkg::SUM_W'(cth2_ff) <<< 32;
   end

   always_ff @(posedge clock) begin
      if (en[ea2rm_pkg::ST_SUM]) begin
         for (int k = 0; k < ea2rm_pkg::NUM_ENTRIES; k++) begin
            q_ff[k] <= q_in[k];
         end
      end
   end

   // round to Q14, saturate, output register
   ea2rm_pkg::sum_type rq [ea2rm_pkg::NUM_ENTRIES];
   ea2rm_pkg::sum_type cq [ea2rm_pkg::NUM_ENTRIES];
   ea2rm_pkg::entry_type entry_ff [ea2rm_pkg::NUM_ENTRIES];

   always_comb begin
      for (int k = 0; k < ea2rm_pkg::NUM_ENTRIES; k++) begin
         rq[k] = (q_ff[k] + ea2rm_pkg::ENTRY_RND) >>> 34;
         if (rq[k] > ea2rm_pkg::ENTRY_LIM_S) begin
            cq[k] = ea2rm_pkg::ENTRY_LIM_S;
         end else if (rq[k] < -ea2rm_pkg::ENTRY_LIM_S) begin
            cq[k] = -ea2rm_pkg::ENTRY_LIM_S;
         end else begin
            cq[k] = rq[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[NS]) begin
         for (int k = 0; k < ea2rm_pkg::NUM_ENTRIES; k++) begin
            entry_ff[k] <= ea2rm_pkg::ENTRY_BITS'(cq[k]);
         end
      end
   end

   assign rsp_row0_col0 = entry_ff[0];
   assign rsp_row0_col1 = entry_ff[1];
   assign rsp_row0_col2 = entry_ff[2];
   assign rsp_row1_col0 = entry_ff[3];
   assign rsp_row1_col1 = entry_ff[4];
   assign rsp_row1_col2 = entry_ff[5];
   assign rsp_row2_col0 = entry_ff[6];
   assign rsp_row2_col1 = entry_ff[7];
   assign rsp_row2_col2 = entry_ff[8];

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (&v_ff))
      else $error("input stalled while a pipeline stage is empty");

   a_out_valid_from_prev: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(v_ff[NS-1]))
      else $error("result beat appeared without an item in the stage before");

   for (genvar k = 0; k < ea2rm_pkg::NUM_ENTRIES; k++) begin : g_chk
      a_entry_range: assert property (@(posedge clock) disable iff (reset)
         rsp_valid |-> (entry_ff[k] <= ea2rm_pkg::ENTRY_LIM_E)
                    && (entry_ff[k] >= -ea2rm_pkg::ENTRY_LIM_E))
         else $error("matrix entry beyond saturation limit");
   end

endmodule
